>>> rtl/point_segment_distance_defines.svh
// ----------------------------------------------------------------------------
// Point-to-segment distance: assertion macros
// Shared assertion helpers; defining NO_ASSERTIONS turns them all into nothing.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent holds in the same cycle as the antecedent.
`define PSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent holds once the delay dly has passed after the antecedent.
`define PSD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);
`else
`define PSD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define PSD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg)
`endif

`endif

>>> rtl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-segment distance package
// Word types, widths and region codes shared by the pipeline modules.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Coordinate differences, products, sums and magnitudes.
    localparam int DIFF_W = 33;
    localparam int PROD_W = 66;
    localparam int SUM_W  = 67;
    localparam int MAG_W  = 66;
    localparam int HALF_W = 33;
    localparam int NUM_W  = 131;
    localparam int ROOT_W = 33;
    localparam int REM_W  = 34;

    // Region codes.
    localparam logic [1:0] REG_DEGEN  = 2'd0;
    localparam logic [1:0] REG_NEAR_A = 2'd1;
    localparam logic [1:0] REG_NEAR_B = 2'd2;
    localparam logic [1:0] REG_PERP   = 2'd3;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic [32:0] distance;
        logic [1:0]  region;
    } t_out_word;

    // Geometry after classification: cross magnitude, squared length and the
    // squared endpoint distance used outside the perpendicular region.
    typedef struct packed {
        logic [1:0]       region;
        logic [MAG_W-1:0] cmag;
        logic [MAG_W-1:0] len2;
        logic [MAG_W-1:0] alt;
    } t_geom_word;

    // Value whose integer square root is the distance.
    typedef struct packed {
        logic [1:0]       region;
        logic [MAG_W-1:0] radicand;
    } t_rad_word;

endpackage

>>> rtl/psd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-segment distance: front end
// Three stages: coordinate differences, exact products, sums and region choice.
// ----------------------------------------------------------------------------
`include "point_segment_distance_defines.svh"

module psd_front
    import psd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_word   i_word,
    output logic       o_valid,
    output t_geom_word o_geom
);

    logic                     r1_valid;
    logic signed [DIFF_W-1:0] r1_v1x, r1_v1y, r1_v2x, r1_v2y, r1_v3x, r1_v3y;
    logic signed [DIFF_W-1:0] n1_v1x, n1_v1y, n1_v2x, n1_v2y, n1_v3x, n1_v3y;

    logic                     r2_valid, r2_deg;
    logic signed [PROD_W-1:0] r2_d1a, r2_d1b, r2_d2a, r2_d2b, r2_ca, r2_cb;
    logic signed [PROD_W-1:0] r2_l1, r2_l2, r2_a1, r2_a2, r2_b1, r2_b2;

    logic                     r3_valid;
    t_geom_word               r3_geom;
    logic signed [SUM_W-1:0]  n3_dot1, n3_dot2, n3_cross, n3_len, n3_da, n3_db;
    logic signed [SUM_W-1:0]  n3_cabs;
    t_geom_word               n3_geom;

    // Stage 1: differences B-A, P-A, P-B.
    always_comb begin
        n1_v1x = DIFF_W'(i_word.end_x)   - DIFF_W'(i_word.start_x);
        n1_v1y = DIFF_W'(i_word.end_y)   - DIFF_W'(i_word.start_y);
        n1_v2x = DIFF_W'(i_word.point_x) - DIFF_W'(i_word.start_x);
        n1_v2y = DIFF_W'(i_word.point_y) - DIFF_W'(i_word.start_y);
        n1_v3x = DIFF_W'(i_word.point_x) - DIFF_W'(i_word.end_x);
        n1_v3y = DIFF_W'(i_word.point_y) - DIFF_W'(i_word.end_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_v1x <= n1_v1x;
        r1_v1y <= n1_v1y;
        r1_v2x <= n1_v2x;
        r1_v2y <= n1_v2y;
        r1_v3x <= n1_v3x;
        r1_v3y <= n1_v3y;
    end

    // Stage 2: all exact products of the differences.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_deg <= (r1_v1x == '0) && (r1_v1y == '0);
        r2_d1a <= r1_v1x * r1_v2x;
        r2_d1b <= r1_v1y * r1_v2y;
        r2_d2a <= r1_v1x * r1_v3x;
        r2_d2b <= r1_v1y * r1_v3y;
        r2_ca  <= r1_v1x * r1_v2y;
        r2_cb  <= r1_v1y * r1_v2x;
        r2_l1  <= r1_v1x * r1_v1x;
        r2_l2  <= r1_v1y * r1_v1y;
        r2_a1  <= r1_v2x * r1_v2x;
        r2_a2  <= r1_v2y * r1_v2y;
        r2_b1  <= r1_v3x * r1_v3x;
        r2_b2  <= r1_v3y * r1_v3y;
    end

    // Stage 3: dot products, cross product, squared lengths and region.
    always_comb begin
        n3_dot1  = SUM_W'(r2_d1a) + SUM_W'(r2_d1b);
        n3_dot2  = SUM_W'(r2_d2a) + SUM_W'(r2_d2b);
        n3_cross = SUM_W'(r2_ca)  - SUM_W'(r2_cb);
        n3_len   = SUM_W'(r2_l1)  + SUM_W'(r2_l2);
        n3_da    = SUM_W'(r2_a1)  + SUM_W'(r2_a2);
        n3_db    = SUM_W'(r2_b1)  + SUM_W'(r2_b2);
        n3_cabs  = n3_cross[SUM_W-1] ? -n3_cross : n3_cross;

        n3_geom.cmag = n3_cabs[MAG_W-1:0];
        n3_geom.len2 = n3_len[MAG_W-1:0];
        n3_geom.alt  = n3_da[MAG_W-1:0];
        if (r2_deg) begin
            n3_geom.region = REG_DEGEN;
        end else if (n3_dot1 < 0) begin
            n3_geom.region = REG_NEAR_A;
        end else if (n3_dot2 > 0) begin
            n3_geom.region = REG_NEAR_B;
            n3_geom.alt    = n3_db[MAG_W-1:0];
        end else begin
            n3_geom.region = REG_PERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_geom <= n3_geom;
    end

    assign o_valid = r3_valid;
    assign o_geom  = r3_geom;

    `PSD_ASSERT_IMPLY(a_perp_len_nonzero, i_clk, i_rst_n, r3_valid && (r3_geom.region == REG_PERP), r3_geom.len2 != '0, "perpendicular region with zero segment length")

endmodule

>>> rtl/psd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-segment distance: squared cross product divided by squared length
// Squares the cross magnitude in two stages, then a restoring divider that
// settles one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "point_segment_distance_defines.svh"

module psd_div
    import psd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_geom_word i_geom,
    output logic       o_valid,
    output t_rad_word  o_rad
);

    localparam int STEPS = MAG_W;

    // Square stage: partial products of the split cross magnitude.
    logic                     rs_valid;
    logic [1:0]               rs_region;
    logic [MAG_W-1:0]         rs_len, rs_alt;
    logic [2*HALF_W-1:0]      rs_hh, rs_hl, rs_ll;

    // Sum stage: full numerator, seeds the divider.
    logic                     rn_valid;
    logic [1:0]               rn_region;
    logic [MAG_W-1:0]         rn_len, rn_alt;
    logic [NUM_W-1:0]         rn_num;
    logic [NUM_W-1:0]         n_num;

    // Divider stages 1..STEPS.
    logic                     r_dv_valid  [1:STEPS];
    logic [1:0]               r_dv_region [1:STEPS];
    logic [MAG_W-1:0]         r_dv_len    [1:STEPS];
    logic [MAG_W-1:0]         r_dv_alt    [1:STEPS];
    logic [MAG_W-1:0]         r_dv_rem    [1:STEPS];
    logic [MAG_W-1:0]         r_dv_low    [1:STEPS];
    logic [MAG_W-1:0]         r_dv_quo    [1:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_valid <= 1'b0;
        end else begin
            rs_valid <= i_valid;
        end
        rs_region <= i_geom.region;
        rs_len    <= i_geom.len2;
        rs_alt    <= i_geom.alt;
        rs_hh     <= i_geom.cmag[MAG_W-1:HALF_W] * i_geom.cmag[MAG_W-1:HALF_W];
        rs_hl     <= i_geom.cmag[MAG_W-1:HALF_W] * i_geom.cmag[HALF_W-1:0];
        rs_ll     <= i_geom.cmag[HALF_W-1:0] * i_geom.cmag[HALF_W-1:0];
    end

    // Combine partial products: hh * 2^66 + 2 * hl * 2^33 + ll.
    assign n_num = (NUM_W'(rs_hh) << (2 * HALF_W)) + (NUM_W'(rs_hl) << (HALF_W + 1))
                 + NUM_W'(rs_ll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rn_valid <= 1'b0;
        end else begin
            rn_valid <= rs_valid;
        end
        rn_region <= rs_region;
        rn_len    <= rs_len;
        rn_alt    <= rs_alt;
        rn_num    <= n_num;
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic             w_valid;
        logic [1:0]       w_region;
        logic [MAG_W-1:0] w_len, w_alt, w_rem, w_low, w_quo;
        logic [MAG_W:0]   w_trial;
        logic             w_ge;

        if (k == 0) begin : g_seed
            assign w_valid  = rn_valid;
            assign w_region = rn_region;
            assign w_len    = rn_len;
            assign w_alt    = rn_alt;
            assign w_rem    = MAG_W'(rn_num[NUM_W-1:MAG_W]);
            assign w_low    = rn_num[MAG_W-1:0];
            assign w_quo    = '0;
        end else begin : g_chain
            assign w_valid  = r_dv_valid[k];
            assign w_region = r_dv_region[k];
            assign w_len    = r_dv_len[k];
            assign w_alt    = r_dv_alt[k];
            assign w_rem    = r_dv_rem[k];
            assign w_low    = r_dv_low[k];
            assign w_quo    = r_dv_quo[k];
        end

        assign w_trial = {w_rem, w_low[MAG_W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_len});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else begin
                r_dv_valid[k+1] <= w_valid;
            end
            r_dv_region[k+1] <= w_region;
            r_dv_len[k+1]    <= w_len;
            r_dv_alt[k+1]    <= w_alt;
            r_dv_rem[k+1]    <= w_ge ? MAG_W'(w_trial - {1'b0, w_len}) : w_trial[MAG_W-1:0];
            r_dv_low[k+1]    <= {w_low[MAG_W-2:0], 1'b0};
            r_dv_quo[k+1]    <= {w_quo[MAG_W-2:0], w_ge};
        end
    end

    assign o_valid         = r_dv_valid[STEPS];
    assign o_rad.region    = r_dv_region[STEPS];
    assign o_rad.radicand  = (r_dv_region[STEPS] == REG_PERP) ? r_dv_quo[STEPS]
                                                              : r_dv_alt[STEPS];

    `PSD_ASSERT_IMPLY(a_rem_below_len, i_clk, i_rst_n, r_dv_valid[STEPS] && (r_dv_region[STEPS] == REG_PERP), r_dv_rem[STEPS] < r_dv_len[STEPS], "divider remainder not below divisor")

endmodule

>>> rtl/psd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-segment distance: integer square root
// Digit-by-digit square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
`include "point_segment_distance_defines.svh"

module psd_sqrt
    import psd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_rad_word i_rad,
    output logic      o_valid,
    output t_out_word o_out
);

    localparam int STEPS = ROOT_W;

    logic               r_sq_valid  [1:STEPS];
    logic [1:0]         r_sq_region [1:STEPS];
    logic [REM_W-1:0]   r_sq_rem    [1:STEPS];
    logic [ROOT_W-1:0]  r_sq_root   [1:STEPS];
    logic [MAG_W-1:0]   r_sq_op     [1:STEPS];

    // Each stage brings down two radicand bits and decides one root bit.
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic              w_valid;
        logic [1:0]        w_region;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [MAG_W-1:0]  w_op;
        logic [REM_W+1:0]  w_cur, w_trial;
        logic              w_ge;

        if (k == 0) begin : g_seed
            assign w_valid  = i_valid;
            assign w_region = i_rad.region;
            assign w_rem    = '0;
            assign w_root   = '0;
            assign w_op     = i_rad.radicand;
        end else begin : g_chain
            assign w_valid  = r_sq_valid[k];
            assign w_region = r_sq_region[k];
            assign w_rem    = r_sq_rem[k];
            assign w_root   = r_sq_root[k];
            assign w_op     = r_sq_op[k];
        end

        assign w_cur   = {w_rem, w_op[MAG_W-1:MAG_W-2]};
        assign w_trial = {1'b0, w_root, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else begin
                r_sq_valid[k+1] <= w_valid;
            end
            r_sq_region[k+1] <= w_region;
            r_sq_rem[k+1]    <= w_ge ? REM_W'(w_cur - w_trial) : w_cur[REM_W-1:0];
            r_sq_root[k+1]   <= {w_root[ROOT_W-2:0], w_ge};
            r_sq_op[k+1]     <= {w_op[MAG_W-3:0], 2'b00};
        end
    end

    assign o_valid        = r_sq_valid[STEPS];
    assign o_out.distance = r_sq_root[STEPS];
    assign o_out.region   = r_sq_region[STEPS];

    `PSD_ASSERT_IMPLY(a_root_not_low, i_clk, i_rst_n, r_sq_valid[STEPS], r_sq_rem[STEPS] <= {r_sq_root[STEPS], 1'b0}, "square root remainder too large")

endmodule

>>> rtl/point_segment_distance.sv
// Throughput: one word per cycle; busy is never raised, the pipeline takes start every cycle.
// Depth comes from the 66-stage divider and the 33-stage square root, one bit per stage.
// The receiver cannot stall; each result is on o_out for exactly one cycle with o_strobe.
// Reset is synchronous and active low; it clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-segment distance, top level
// Euclidean distance from a Q16.16 point to a segment, truncated to Q17.16.
// ----------------------------------------------------------------------------
`include "point_segment_distance_defines.svh"

module point_segment_distance
    import psd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_strobe,
    output t_out_word o_out
);

    localparam int LATENCY = 104;

    logic       w_geom_valid, w_rad_valid, w_accept;
    t_geom_word w_geom;
    t_rad_word  w_rad;

    // The pipeline never holds off a word.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_word  (i_in),
        .o_valid (w_geom_valid),
        .o_geom  (w_geom)
    );

    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geom_valid),
        .i_geom  (w_geom),
        .o_valid (w_rad_valid),
        .o_rad   (w_rad)
    );

    psd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rad_valid),
        .i_rad   (w_rad),
        .o_valid (o_strobe),
        .o_out   (o_out)
    );

    `PSD_ASSERT_DELAY(a_word_delivered, i_clk, i_rst_n, w_accept, LATENCY, o_strobe, "accepted word did not produce a result")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-segment distance testbench
// Streams directed and random geometry words into the pipeline, predicts
// each distance and region with exact wide integer arithmetic, and checks
// every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import psd_pkg::*;

    typedef logic signed [139:0] t_big;

    localparam int N_RANDOM = 2000;
    localparam int DRAIN_AT = 900;
    localparam int QUIET_TAIL = 200;
    localparam int PIPE_DEPTH = 104;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_in;
    logic      o_strobe;
    t_out_word o_out;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    int        error_count;
    int        total_words;
    logic      taken;
    logic      feeding_done;

    point_segment_distance u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bitwise integer square root, floor.
    function automatic logic [32:0] int_sqrt(input t_big n);
        logic [67:0] root;
        logic [67:0] cand;
        t_big        sq;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (68'd1 << b);
            sq = t_big'(cand) * t_big'(cand);
            if (sq <= n) root = cand;
        end
        return root[32:0];
    endfunction

    // Exact distance and region of one geometry word.
    function automatic t_out_word seg_distance(input t_in_word w);
        t_big v1x, v1y, v2x, v2y, v3x, v3y, dot_a, dot_b, cross_p, len2;
        t_out_word r;
        v1x = t_big'(w.end_x) - t_big'(w.start_x);
        v1y = t_big'(w.end_y) - t_big'(w.start_y);
        v2x = t_big'(w.point_x) - t_big'(w.start_x);
        v2y = t_big'(w.point_y) - t_big'(w.start_y);
        v3x = t_big'(w.point_x) - t_big'(w.end_x);
        v3y = t_big'(w.point_y) - t_big'(w.end_y);
        dot_a = v1x * v2x + v1y * v2y;
        dot_b = v1x * v3x + v1y * v3y;
        if (v1x == 0 && v1y == 0) begin
            r.region = REG_DEGEN;
            r.distance = int_sqrt(v2x * v2x + v2y * v2y);
        end else if (dot_a < 0) begin
            r.region = REG_NEAR_A;
            r.distance = int_sqrt(v2x * v2x + v2y * v2y);
        end else if (dot_b > 0) begin
            r.region = REG_NEAR_B;
            r.distance = int_sqrt(v3x * v3x + v3y * v3y);
        end else begin
            cross_p = v1x * v2y - v1y * v2x;
            len2 = v1x * v1x + v1y * v1y;
            r.region = REG_PERP;
            r.distance = int_sqrt((cross_p * cross_p) / len2);
        end
        return r;
    endfunction

    function automatic t_in_word make_word(input int px, py, ax, ay, bx, by);
        t_in_word w;
        w.point_x = px; w.point_y = py;
        w.start_x = ax; w.start_y = ay;
        w.end_x = bx; w.end_y = by;
        return w;
    endfunction

    // Random coordinate: mostly small, sometimes full range.
    function automatic int rand_coord(input int kind);
        case (kind)
            0: return $urandom;
            1: return int'($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
            default: return (int'($urandom_range(0, 40)) - 20) <<< 16;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input t_out_word got,
                                   input t_out_word want);
        $display("mismatch %s: got dist %0d region %0d, want dist %0d region %0d",
                 what, got.distance, got.region, want.distance, want.region);
        error_count++;
    endtask

    // Stimulus: directed corners first, then random words.
    initial begin
        t_in_word w;
        int kind;
        int mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        error_count = 0;
        // Degenerate segments, including extreme points.
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(mx, mx, mn, mn, mn, mn));
        pending_words.push_back(make_word(mn, mx, mx, mn, mx, mn));
        pending_words.push_back(make_word(3 <<< 16, 4 <<< 16, 0, 0, 0, 0));
        // Projection before the first endpoint and past the second.
        pending_words.push_back(make_word(-5 <<< 16, 1 <<< 16, 0, 0, 10 <<< 16, 0));
        pending_words.push_back(make_word(15 <<< 16, 1 <<< 16, 0, 0, 10 <<< 16, 0));
        pending_words.push_back(make_word(mn, mn, 0, 0, mx, mx));
        pending_words.push_back(make_word(mx, mx, mn, mn, 0, 0));
        // Perpendicular region.
        pending_words.push_back(make_word(5 <<< 16, 7 <<< 16, 0, 0, 10 <<< 16, 0));
        pending_words.push_back(make_word(1, mx, 0, mn, 3, mx));
        pending_words.push_back(make_word(0, mx, mn, mn, mx, mn));
        pending_words.push_back(make_word(mx, mn, mn, mx, mx, mx));
        // Dot product exactly zero at either endpoint.
        pending_words.push_back(make_word(0, 6 <<< 16, 0, 0, 10 <<< 16, 0));
        pending_words.push_back(make_word(10 <<< 16, -6 <<< 16, 0, 0, 10 <<< 16, 0));
        pending_words.push_back(make_word(mn, mx, mn, mn, mx, mn));
        pending_words.push_back(make_word(mx, mx, mn, mn, mx, mn));
        // Point on the segment and on an endpoint.
        pending_words.push_back(make_word(5, 5, 0, 0, 10, 10));
        pending_words.push_back(make_word(10, 10, 0, 0, 10, 10));
        pending_words.push_back(make_word(-1, -1, -1, -1, 1, 1));
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 2);
            w = make_word(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                          rand_coord(kind), rand_coord(kind), rand_coord(kind));
            if ($urandom_range(0, 19) == 0) begin
                w.end_x = w.start_x;
                w.end_y = w.start_y;
            end
            pending_words.push_back(w);
        end
        total_words = pending_words.size();
    end

    // Reset.
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Driver: presents words at the falling edge, with random idle bursts.
    int  idle_left = 0;
    int  sent = 0;
    bit  drained = 0;
    initial begin
        start = 1'b0;
        i_in = '0;
        taken = 1'b0;
        feeding_done = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!start || taken) begin
            taken <= 1'b0;
            if (!i_rst_n || pending_words.size() == 0) begin
                start <= 1'b0;
                if (i_rst_n && total_words > 0) feeding_done <= 1'b1;
            end else if (sent == DRAIN_AT && !drained) begin
                // Let the pipeline empty out once before going on.
                start <= 1'b0;
                if (expected_results.size() == 0) drained = 1;
            end else if (idle_left > 0) begin
                start <= 1'b0;
                idle_left--;
            end else begin
                i_in <= pending_words.pop_front();
                start <= 1'b1;
                sent++;
                if (sent < total_words - QUIET_TAIL && $urandom_range(0, 7) == 0)
                    idle_left = $urandom_range(1, 5);
            end
        end
    end

    // Monitor: records accepted words and checks strobed results.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(seg_distance(i_in));
            taken <= 1'b1;
        end
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_out, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_out.distance !== want.distance)
                    report_mismatch("distance", o_out, want);
                if (o_out.region !== want.region)
                    report_mismatch("region", o_out, want);
            end
        end
    end

    // End of run.
    initial begin
        wait (feeding_done === 1'b1 && start === 1'b0);
        wait (expected_results.size() == 0);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/psd_div.sv
rtl/psd_sqrt.sv
rtl/point_segment_distance.sv
tb/tb_top.sv
